### sv/tct_pkg.sv
// Shared types, constants and a helper function for the triple countdown timer block.
package tct_pkg;

  // Default timer count and command queue depth.
  localparam int NUM_TIMERS_DEF = 3;
  localparam int QUEUE_DEPTH    = 2;
  localparam int IRQ_W          = 3;
  localparam int TIMER_SEL_W    = 3;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 12;
  localparam int OP_W           = 2;

  // Operation codes carried by the input word.
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Register offsets within a timer's 32-byte window.
  localparam logic [4:0] OFS_LOAD  = 5'd0;
  localparam logic [4:0] OFS_VALUE = 5'd4;
  localparam logic [4:0] OFS_CTRL  = 5'd8;
  localparam logic [4:0] OFS_RIS   = 5'd12;
  localparam logic [4:0] OFS_MIS   = 5'd16;

  // Control register bits and special values.
  localparam int CTRL_ENABLE_BIT = 0;
  localparam int CTRL_ONESHOT_BIT = 3;
  localparam int CTRL_MASK_BIT   = 4;
  localparam logic [DATA_W-1:0] CTRL_RESET  = 32'h0000_0010;
  localparam logic [DATA_W-1:0] FREE_RELOAD = 32'hffff_ffff;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_READ,
    KIND_WRITE,
    KIND_TICK,
    KIND_BAD
  } cmd_kind_t;

  typedef enum logic [2:0] {
    REG_LOAD,
    REG_VALUE,
    REG_CTRL,
    REG_RIS,
    REG_MIS
  } reg_sel_t;

  // Decoded command passed from the front end to the timer bank.
  typedef struct packed {
    cmd_kind_t              kind;
    logic [TIMER_SEL_W-1:0] timer;
    reg_sel_t               reg_sel;
    logic [DATA_W-1:0]      data;
  } cmd_t;

  // Value a counter takes on reload: all ones in enabled free-running mode.
  function automatic logic [DATA_W-1:0] reload_of(input logic [DATA_W-1:0] ctrl,
                                                   input logic [DATA_W-1:0] load);
    logic [DATA_W-1:0] r;
    if (ctrl[3:2] == 2'b00 && ctrl[CTRL_ENABLE_BIT]) begin
      r = FREE_RELOAD;
    end else begin
      r = load;
    end
    return r;
  endfunction

endpackage

### sv/tct_front.sv
// Front end: accepts input words and decodes them into timer bank commands.
module tct_front #(
  parameter int NUM_TIMERS = tct_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tct_pkg::OP_W-1:0]    operation,
  input  logic [tct_pkg::ADDR_W-1:0]  address,
  input  logic [tct_pkg::DATA_W-1:0]  write_data,
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output tct_pkg::cmd_t               cmd
);

  tct_pkg::cmd_t cmd_next;
  logic          advance;
  logic          good;
  logic [4:0]    ofs;

  // The stage moves on when it is empty or the queue takes its word.
  assign advance  = !cmd_valid || cmd_ready;
  assign in_stall = !advance;
  assign ofs      = address[4:0];

  // Classify the word: operation, timer select and register offset.
  always_comb begin
    good = (address[tct_pkg::ADDR_W-1:8] == '0) &&
           ({1'b0, address[7:5]} < 4'(NUM_TIMERS));
    cmd_next.timer   = address[7:5];
    cmd_next.data    = write_data;
    cmd_next.kind    = tct_pkg::KIND_NOP;
    cmd_next.reg_sel = tct_pkg::REG_LOAD;
    case (ofs)
      tct_pkg::OFS_LOAD:  cmd_next.reg_sel = tct_pkg::REG_LOAD;
      tct_pkg::OFS_VALUE: cmd_next.reg_sel = tct_pkg::REG_VALUE;
      tct_pkg::OFS_CTRL:  cmd_next.reg_sel = tct_pkg::REG_CTRL;
      tct_pkg::OFS_RIS:   cmd_next.reg_sel = tct_pkg::REG_RIS;
      tct_pkg::OFS_MIS:   cmd_next.reg_sel = tct_pkg::REG_MIS;
      default:            good = 1'b0;
    endcase
    case (operation)
      tct_pkg::OP_READ:  cmd_next.kind = good ? tct_pkg::KIND_READ  : tct_pkg::KIND_BAD;
      tct_pkg::OP_WRITE: cmd_next.kind = good ? tct_pkg::KIND_WRITE : tct_pkg::KIND_BAD;
      tct_pkg::OP_TICK:  cmd_next.kind = tct_pkg::KIND_TICK;
      default:           cmd_next.kind = tct_pkg::KIND_NOP;
    endcase
  end

  // Stage register holding one decoded word.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (advance) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      cmd <= cmd_next;
    end
  end

endmodule

### sv/tct_queue.sv
// Short command queue between the front end and the timer bank.
module tct_queue #(
  parameter int DEPTH = tct_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tct_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_stall,
  output tct_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tct_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && !pop_stall;
  assign pop_cmd    = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // The fill count never passes the depth and an empty queue is never drained.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop)
    else $error("pop from empty queue");

endmodule

### sv/tct_bank.sv
// Timer bank: holds timer state, executes commands and registers each result word.
module tct_bank #(
  parameter int NUM_TIMERS = tct_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  tct_pkg::cmd_t               cmd,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tct_pkg::DATA_W-1:0]  read_data,
  output logic [tct_pkg::IRQ_W-1:0]   irq_lines,
  output logic                        bad_access
);

  localparam int IRQ_N = (NUM_TIMERS < tct_pkg::IRQ_W) ? NUM_TIMERS : tct_pkg::IRQ_W;

  logic [tct_pkg::DATA_W-1:0] ctrl       [NUM_TIMERS];
  logic [tct_pkg::DATA_W-1:0] load       [NUM_TIMERS];
  logic [tct_pkg::DATA_W-1:0] count      [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]      running;
  logic [NUM_TIMERS-1:0]      pending;
  logic [tct_pkg::DATA_W-1:0] ctrl_next  [NUM_TIMERS];
  logic [tct_pkg::DATA_W-1:0] load_next  [NUM_TIMERS];
  logic [tct_pkg::DATA_W-1:0] count_next [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]      running_next;
  logic [NUM_TIMERS-1:0]      pending_next;
  logic [tct_pkg::DATA_W-1:0] rdata;
  logic [tct_pkg::IRQ_W-1:0]  irq_next;
  logic [tct_pkg::IRQ_W-1:0]  irq_now;
  logic                       take;
  logic                       sel;

  // A command is executed whenever the output register can take its result.
  assign take      = cmd_valid && (!out_valid || !out_stall);
  assign cmd_stall = !take;

  // Per-timer update and read selection; each timer is independent.
  always_comb begin
    rdata = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      sel             = (cmd.timer == tct_pkg::TIMER_SEL_W'(t));
      ctrl_next[t]    = ctrl[t];
      load_next[t]    = load[t];
      count_next[t]   = count[t];
      running_next[t] = running[t];
      pending_next[t] = pending[t];
      if (take) begin
        case (cmd.kind)
          tct_pkg::KIND_TICK: begin
            if (running[t]) begin
              if (count[t] <= tct_pkg::DATA_W'(1)) begin
                pending_next[t] = 1'b1;
                if (ctrl[t][tct_pkg::CTRL_ONESHOT_BIT]) begin
                  count_next[t]   = '0;
                  running_next[t] = 1'b0;
                end else begin
                  count_next[t] = tct_pkg::reload_of(ctrl[t], load[t]);
                end
              end else begin
                count_next[t] = count[t] - 1'b1;
              end
            end
          end
          tct_pkg::KIND_READ: begin
            if (sel) begin
              case (cmd.reg_sel)
                tct_pkg::REG_LOAD:  rdata = load[t];
                tct_pkg::REG_VALUE: rdata = count[t];
                tct_pkg::REG_CTRL:  rdata = ctrl[t];
                tct_pkg::REG_RIS: begin
                  rdata           = tct_pkg::DATA_W'(pending[t]);
                  pending_next[t] = 1'b0;
                end
                tct_pkg::REG_MIS:
                  rdata = tct_pkg::DATA_W'(pending[t] && !ctrl[t][tct_pkg::CTRL_MASK_BIT]);
                default: rdata = '0;
              endcase
            end
          end
          tct_pkg::KIND_WRITE: begin
            if (sel) begin
              case (cmd.reg_sel)
                tct_pkg::REG_LOAD: begin
                  load_next[t]  = cmd.data;
                  count_next[t] = tct_pkg::reload_of(ctrl[t], cmd.data);
                end
                tct_pkg::REG_CTRL: begin
                  ctrl_next[t]    = cmd.data;
                  running_next[t] = cmd.data[tct_pkg::CTRL_ENABLE_BIT];
                  if (cmd.data[tct_pkg::CTRL_ENABLE_BIT]) begin
                    count_next[t] = tct_pkg::reload_of(cmd.data, load[t]);
                  end
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Interrupt lines after the update, and from the present state for checking.
  always_comb begin
    irq_next = '0;
    irq_now  = '0;
    for (int t = 0; t < IRQ_N; t++) begin
      irq_next[t] = pending_next[t] && !ctrl_next[t][tct_pkg::CTRL_MASK_BIT];
      irq_now[t]  = pending[t] && !ctrl[t][tct_pkg::CTRL_MASK_BIT];
    end
  end

  // Timer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        ctrl[t]  <= tct_pkg::CTRL_RESET;
        load[t]  <= '0;
        count[t] <= '0;
      end
      running <= '0;
      pending <= '0;
    end else begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        ctrl[t]  <= ctrl_next[t];
        load[t]  <= load_next[t];
        count[t] <= count_next[t];
      end
      running <= running_next;
      pending <= pending_next;
    end
  end

  // Output register: one result word per executed command.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      read_data  <= rdata;
      irq_lines  <= irq_next;
      bad_access <= (cmd.kind == tct_pkg::KIND_BAD);
    end
  end

  // State only moves with a new result, so a held word matches the live interrupts.
  a_irq_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq_lines == irq_now))
    else $error("irq_lines out of step with timer state");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_access) |-> (read_data == '0))
    else $error("bad access returned data");

endmodule

### sv/triple_countdown_timer_regs_unit.sv
// Words pass the front-end stage, the command queue and the bank's output register.
// Throughput: one word per cycle unless the output stalls, set by the bank update.
// A two-entry command queue lets the front end keep accepting while the output stalls.
// Reset (rst, synchronous): all timers stopped, counts and loads zero, control 0x10,
// no interrupts pending, queue and output empty.
module triple_countdown_timer_regs_unit #(
  parameter int NUM_TIMERS = tct_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tct_pkg::OP_W-1:0]    operation,
  input  logic [tct_pkg::ADDR_W-1:0]  address,
  input  logic [tct_pkg::DATA_W-1:0]  write_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tct_pkg::DATA_W-1:0]  read_data,
  output logic [tct_pkg::IRQ_W-1:0]   irq_lines,
  output logic                        bad_access
);

  logic          f_valid;
  logic          f_ready;
  tct_pkg::cmd_t f_cmd;
  logic          q_valid;
  logic          q_stall;
  tct_pkg::cmd_t q_cmd;

  // Front end decodes each input word.
  tct_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .address    (address),
    .write_data (write_data),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  // Queue decouples decode from execution.
  tct_queue #(.DEPTH(tct_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_cmd    (q_cmd)
  );

  // Timer bank executes commands and drives the result word.
  tct_bank #(.NUM_TIMERS(NUM_TIMERS)) u_bank (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_stall  (q_stall),
    .cmd        (q_cmd),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .irq_lines  (irq_lines),
    .bad_access (bad_access)
  );

endmodule

### verif/tb_triple_countdown_timer_regs_unit.sv
// Self-checking testbench for the triple countdown timer register block.
`timescale 1ns / 100ps

module tb_triple_countdown_timer_regs_unit;

  localparam int NUM_T = tct_pkg::NUM_TIMERS_DEF;
  localparam logic [tct_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CTRL_PERIODIC_BIT = 2;
  localparam logic [tct_pkg::ADDR_W-1:0] REGION_LIMIT = 12'h100;
  localparam int PHASE_WORDS = 150;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [tct_pkg::OP_W-1:0]   op;
    logic [tct_pkg::ADDR_W-1:0] addr;
    logic [tct_pkg::DATA_W-1:0] data;
  } bus_word_t;

  typedef struct packed {
    logic [tct_pkg::DATA_W-1:0] rdata;
    logic [tct_pkg::IRQ_W-1:0]  irq;
    logic                       bad;
  } timer_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [tct_pkg::OP_W-1:0] operation = '0;
  logic [tct_pkg::ADDR_W-1:0] address = '0;
  logic [tct_pkg::DATA_W-1:0] write_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [tct_pkg::DATA_W-1:0] read_data;
  logic [tct_pkg::IRQ_W-1:0] irq_lines;
  logic bad_access;

  // Words waiting to be offered, and results the timer bank should still return.
  bus_word_t pending_words[$];
  timer_resp_t expected_resps[$];
  bus_word_t next_word;
  timer_resp_t pred_resp;
  timer_resp_t got_resp;
  timer_resp_t want_resp;

  // Shadow copy of the timer bank.
  logic [tct_pkg::DATA_W-1:0] tmr_ctrl[NUM_T];
  logic [tct_pkg::DATA_W-1:0] tmr_load[NUM_T];
  logic [tct_pkg::DATA_W-1:0] tmr_count[NUM_T];
  logic tmr_run[NUM_T];
  logic tmr_irq[NUM_T];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int mismatch_cnt = 0;
  int stim_count = 0;
  int directed_count = 0;
  int n_ticks = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_bad = 0;
  int n_irq_words = 0;
  int n_checked = 0;

  triple_countdown_timer_regs_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .irq_lines  (irq_lines),
    .bad_access (bad_access)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reload value of a timer: all ones when enabled in free-running mode.
  function automatic logic [tct_pkg::DATA_W-1:0] reload_value(int t);
    if (tmr_ctrl[t][tct_pkg::CTRL_ONESHOT_BIT:CTRL_PERIODIC_BIT] == 2'b00 &&
        tmr_ctrl[t][tct_pkg::CTRL_ENABLE_BIT]) begin
      return tct_pkg::FREE_RELOAD;
    end
    return tmr_load[t];
  endfunction

  // Applies one bus word to the shadow timers and returns the result word it gives.
  function automatic timer_resp_t predict_access(bus_word_t w);
    timer_resp_t r;
    int t;
    logic [4:0] ofs;
    logic good;
    r = '0;
    t = int'(w.addr[7:5]);
    ofs = w.addr[4:0];
    good = (w.addr < REGION_LIMIT) && (t < NUM_T) &&
           (ofs == tct_pkg::OFS_LOAD || ofs == tct_pkg::OFS_VALUE ||
            ofs == tct_pkg::OFS_CTRL || ofs == tct_pkg::OFS_RIS ||
            ofs == tct_pkg::OFS_MIS);
    if (w.op == tct_pkg::OP_TICK) begin
      for (int i = 0; i < NUM_T; i++) begin
        if (tmr_run[i]) begin
          if (tmr_count[i] <= 1) begin
            tmr_irq[i] = 1'b1;
            if (tmr_ctrl[i][tct_pkg::CTRL_ONESHOT_BIT]) begin
              tmr_count[i] = '0;
              tmr_run[i] = 1'b0;
            end else begin
              tmr_count[i] = reload_value(i);
            end
          end else begin
            tmr_count[i] = tmr_count[i] - 1;
          end
        end
      end
    end else if (w.op == tct_pkg::OP_READ || w.op == tct_pkg::OP_WRITE) begin
      if (!good) begin
        r.bad = 1'b1;
      end else if (w.op == tct_pkg::OP_READ) begin
        case (ofs)
          tct_pkg::OFS_LOAD:  r.rdata = tmr_load[t];
          tct_pkg::OFS_VALUE: r.rdata = tmr_count[t];
          tct_pkg::OFS_CTRL:  r.rdata = tmr_ctrl[t];
          tct_pkg::OFS_RIS: begin
            r.rdata = {31'd0, tmr_irq[t]};
            tmr_irq[t] = 1'b0;
          end
          default: r.rdata = {31'd0, tmr_irq[t] & ~tmr_ctrl[t][tct_pkg::CTRL_MASK_BIT]};
        endcase
      end else begin
        if (ofs == tct_pkg::OFS_LOAD) begin
          tmr_load[t] = w.data;
          tmr_count[t] = reload_value(t);
        end else if (ofs == tct_pkg::OFS_CTRL) begin
          tmr_ctrl[t] = w.data;
          tmr_run[t] = w.data[tct_pkg::CTRL_ENABLE_BIT];
          if (tmr_run[t]) begin
            tmr_count[t] = reload_value(t);
          end
        end
      end
    end
    // Interrupt lines reflect the state after this word.
    for (int i = 0; i < NUM_T && i < tct_pkg::IRQ_W; i++) begin
      r.irq[i] = tmr_irq[i] & ~tmr_ctrl[i][tct_pkg::CTRL_MASK_BIT];
    end
    return r;
  endfunction

  // Queues one bus word for the driver.
  task automatic add_word(logic [tct_pkg::OP_W-1:0] op, logic [tct_pkg::ADDR_W-1:0] addr,
                          logic [tct_pkg::DATA_W-1:0] data);
    bus_word_t w;
    w.op = op;
    w.addr = addr;
    w.data = data;
    pending_words.push_back(w);
    stim_count++;
  endtask

  function automatic logic [tct_pkg::ADDR_W-1:0] timer_addr(int t, logic [4:0] ofs);
    logic [tct_pkg::TIMER_SEL_W-1:0] sel;
    sel = tct_pkg::TIMER_SEL_W'(t);
    return {4'h0, sel, ofs};
  endfunction

  // Well-formed setup of one timer, then ticks, status reads and other accesses.
  task automatic add_timer_sequence();
    int t;
    int n;
    logic [tct_pkg::DATA_W-1:0] ld;
    logic [tct_pkg::DATA_W-1:0] ctl;
    logic [4:0] good_ofs[5];
    good_ofs = '{tct_pkg::OFS_LOAD, tct_pkg::OFS_VALUE, tct_pkg::OFS_CTRL,
                 tct_pkg::OFS_RIS, tct_pkg::OFS_MIS};
    t = $urandom_range(0, NUM_T - 1);
    ld = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
    ctl = $urandom;
    ctl[tct_pkg::CTRL_ENABLE_BIT] = ($urandom_range(0, 9) != 0);
    ctl[tct_pkg::CTRL_MASK_BIT] = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1)) begin
      add_word(tct_pkg::OP_WRITE, timer_addr(t, tct_pkg::OFS_LOAD), ld);
      add_word(tct_pkg::OP_WRITE, timer_addr(t, tct_pkg::OFS_CTRL), ctl);
    end else begin
      add_word(tct_pkg::OP_WRITE, timer_addr(t, tct_pkg::OFS_CTRL), ctl);
      add_word(tct_pkg::OP_WRITE, timer_addr(t, tct_pkg::OFS_LOAD), ld);
    end
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0, 1, 2: add_word(tct_pkg::OP_TICK, tct_pkg::ADDR_W'($urandom), $urandom);
        3:       add_word(tct_pkg::OP_READ, timer_addr(t, tct_pkg::OFS_RIS), $urandom);
        4:       add_word(tct_pkg::OP_READ, timer_addr(t, tct_pkg::OFS_MIS), $urandom);
        default: add_word(tct_pkg::OP_W'($urandom_range(0, 1)),
                          timer_addr($urandom_range(0, NUM_T - 1),
                                     good_ofs[$urandom_range(0, 4)]),
                          $urandom);
      endcase
    end
  endtask

  // Noise: anything at all, or an access inside the region with a random offset.
  task automatic add_noise();
    if ($urandom_range(0, 1)) begin
      add_word(tct_pkg::OP_W'($urandom_range(0, 3)), tct_pkg::ADDR_W'($urandom), $urandom);
    end else begin
      add_word(tct_pkg::OP_W'($urandom_range(0, 1)), {4'h0, 8'($urandom)}, $urandom);
    end
  endtask

  task automatic add_random_words(int count);
    int first;
    first = stim_count;
    while (stim_count - first < count) begin
      if ($urandom_range(0, 3) != 0) begin
        add_timer_sequence();
      end else begin
        add_noise();
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_resps.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: offers the next pending word once the current one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_word.op = operation;
        next_word.addr = address;
        next_word.data = write_data;
        pred_resp = predict_access(next_word);
        expected_resps.push_back(pred_resp);
        if (operation == tct_pkg::OP_TICK) n_ticks++;
        if (operation == tct_pkg::OP_READ) n_reads++;
        if (operation == tct_pkg::OP_WRITE) n_writes++;
        if (pred_resp.bad) n_bad++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          operation <= next_word.op;
          address <= next_word.addr;
          write_data <= next_word.data;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold, counted here so the sender keeps pushing into a stalled block.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  task automatic report_mismatch(string what, logic [tct_pkg::DATA_W-1:0] want,
                                 logic [tct_pkg::DATA_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= SHOWN_MISMATCHES) begin
      $display("Mismatch at cycle %0d on %s: expected 0x%08h, got 0x%08h",
               cycle_cnt, what, want, got);
    end
  endtask

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_resp.rdata = read_data;
        got_resp.irq = irq_lines;
        got_resp.bad = bad_access;
        if (irq_lines != '0) n_irq_words++;
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected result word", '0, got_resp.rdata);
        end else begin
          want_resp = expected_resps.pop_front();
          n_checked++;
          if (got_resp.rdata !== want_resp.rdata) begin
            report_mismatch("read_data", want_resp.rdata, got_resp.rdata);
          end
          if (got_resp.irq !== want_resp.irq) begin
            report_mismatch("irq_lines", tct_pkg::DATA_W'(want_resp.irq),
                            tct_pkg::DATA_W'(got_resp.irq));
          end
          if (got_resp.bad !== want_resp.bad) begin
            report_mismatch("bad_access", tct_pkg::DATA_W'(want_resp.bad),
                            tct_pkg::DATA_W'(got_resp.bad));
          end
        end
      end
      out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int idle_pct[4];
    int stall_pct[4];
    idle_pct = '{0, 74, 0, 38};
    stall_pct = '{0, 0, 74, 38};
    for (int i = 0; i < NUM_T; i++) begin
      tmr_ctrl[i] = tct_pkg::CTRL_RESET;
      tmr_load[i] = '0;
      tmr_count[i] = '0;
      tmr_run[i] = 1'b0;
      tmr_irq[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset values, bad addresses, the unused operation, each timer mode.
    add_word(tct_pkg::OP_READ, timer_addr(0, tct_pkg::OFS_LOAD), '0);
    add_word(tct_pkg::OP_READ, timer_addr(0, tct_pkg::OFS_VALUE), '0);
    add_word(tct_pkg::OP_READ, timer_addr(0, tct_pkg::OFS_CTRL), '0);
    add_word(tct_pkg::OP_READ, timer_addr(0, tct_pkg::OFS_RIS), '0);
    add_word(tct_pkg::OP_READ, timer_addr(0, tct_pkg::OFS_MIS), '0);
    add_word(tct_pkg::OP_READ, REGION_LIMIT, '0);
    add_word(tct_pkg::OP_WRITE, 12'hfff, 32'hffff_ffff);
    add_word(tct_pkg::OP_WRITE, timer_addr(3, tct_pkg::OFS_LOAD), 32'h1234_5678);
    add_word(tct_pkg::OP_READ, timer_addr(7, tct_pkg::OFS_CTRL), '0);
    add_word(tct_pkg::OP_READ, timer_addr(0, 5'h1f), '0);
    add_word(OP_UNUSED, 12'hfff, 32'hffff_ffff);
    // Periodic timer with a short load, unmasked: expires and reloads.
    add_word(tct_pkg::OP_WRITE, timer_addr(1, tct_pkg::OFS_LOAD), 32'd2);
    add_word(tct_pkg::OP_WRITE, timer_addr(1, tct_pkg::OFS_CTRL), 32'h5);
    add_word(tct_pkg::OP_TICK, '0, '0);
    add_word(tct_pkg::OP_TICK, 12'hfff, 32'hffff_ffff);
    add_word(tct_pkg::OP_READ, timer_addr(1, tct_pkg::OFS_MIS), '0);
    // Writes to the read-only registers are ignored without a bad access.
    add_word(tct_pkg::OP_WRITE, timer_addr(1, tct_pkg::OFS_VALUE), 32'hffff_ffff);
    add_word(tct_pkg::OP_WRITE, timer_addr(1, tct_pkg::OFS_RIS), 32'hffff_ffff);
    add_word(tct_pkg::OP_WRITE, timer_addr(1, tct_pkg::OFS_MIS), 32'hffff_ffff);
    add_word(tct_pkg::OP_READ, timer_addr(1, tct_pkg::OFS_RIS), '0);
    // One-shot timer loaded with zero stops on its first tick.
    add_word(tct_pkg::OP_WRITE, timer_addr(2, tct_pkg::OFS_CTRL), 32'h9);
    add_word(tct_pkg::OP_TICK, '0, '0);
    // Free-running timer reloads with all ones.
    add_word(tct_pkg::OP_WRITE, timer_addr(0, tct_pkg::OFS_CTRL), 32'h1);
    add_word(tct_pkg::OP_TICK, '0, '0);
    add_word(tct_pkg::OP_READ, timer_addr(0, tct_pkg::OFS_VALUE), '0);
    add_word(tct_pkg::OP_WRITE, timer_addr(2, tct_pkg::OFS_CTRL), 32'hffff_fffe);
    add_word(tct_pkg::OP_READ, timer_addr(2, tct_pkg::OFS_CTRL), '0);
    directed_count = stim_count;
    wait_drained();

    // Random part in four pacing phases.
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      send_idle_pct = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      if (ph == 0) begin
        // Fill the queue first, then hold the output so the block backs up.
        add_random_words(40);
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
        add_random_words(PHASE_WORDS - 40);
      end else begin
        add_random_words(PHASE_WORDS);
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    $display("Checked %0d result words from %0d directed and %0d random words.",
             n_checked, directed_count, stim_count - directed_count);
    $display("Traffic: %0d ticks, %0d reads, %0d writes, %0d bad accesses, %0d with irq.",
             n_ticks, n_reads, n_writes, n_bad, n_irq_words);
    if (mismatch_cnt == 0 && expected_resps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/tct_pkg.sv
sv/tct_front.sv
sv/tct_queue.sv
sv/tct_bank.sv
sv/triple_countdown_timer_regs_unit.sv
verif/tb_triple_countdown_timer_regs_unit.sv
